/* rtl/core/cluster_charge_matrix_builder_assert.svh */
// Assertion helpers, sampled on clk and disabled while rst_n is low.
`ifndef CLUSTER_CHARGE_MATRIX_BUILDER_ASSERT_SVH
`define CLUSTER_CHARGE_MATRIX_BUILDER_ASSERT_SVH

// same-cycle implication
`define CCMB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CCMB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/ccmb_pkg.sv */
package ccmb_pkg;

  localparam int ROW_W     = 10;
  localparam int CHG_W     = 16;
  localparam int PROD_W    = ROW_W + CHG_W;
  localparam int SUM_W     = 32;
  localparam int TOT_W     = 22;
  localparam int DIM_RAW_W = 4;
  localparam int QW        = 11;
  localparam int POS_W     = 13;
  localparam int OIDX_W    = 6;
  localparam int CFG_IDX_W = 1;

  localparam logic [DIM_RAW_W-1:0] DIM_RESET = 4'd7;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_COLS = 1'd1;

  typedef struct packed {
    logic load;
    logic mul;
    logic acc;
    logic div_start;
    logic centre;
    logic place;
    logic fetch;
    logic advance;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clus_last;
    logic div_done;
    logic place_last;
    logic out_last;
  } sts_t;

endpackage

/* rtl/core/ccmb_div.sv */
module ccmb_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ccmb_pkg::SUM_W-1:0] dividend,
  input  logic [ccmb_pkg::TOT_W-1:0] divisor,
  output logic [ccmb_pkg::QW-1:0]    quotient,
  output logic                       done
);
  import ccmb_pkg::*;

  localparam int CW = $clog2(QW + 1);

  logic              busy_r;
  logic [CW-1:0]     cnt_r;
  logic [TOT_W-1:0]  rem_r;
  logic [TOT_W-1:0]  dvs_r;
  logic [QW-1:0]     qd_r;
  logic [TOT_W:0]    trial;
  logic              qbit;
  logic [TOT_W-1:0]  rem_nxt;

  // quotient never exceeds 2^QW-1, so the top dividend bits start below the divisor
  always_comb begin
    trial   = {rem_r, qd_r[QW-1]};
    qbit    = trial >= {1'b0, dvs_r};
    rem_nxt = qbit ? TOT_W'(trial - {1'b0, dvs_r}) : trial[TOT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(QW);
    end else if (busy_r) begin
      cnt_r  <= cnt_r - 1'b1;
      busy_r <= cnt_r != CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= TOT_W'(dividend[SUM_W-1:QW]);
      qd_r  <= dividend[QW-1:0];
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      qd_r  <= {qd_r[QW-2:0], qbit};
    end
  end

  assign quotient = qd_r;
  assign done     = busy_r && (cnt_r == CW'(1));

endmodule

/* rtl/core/ccmb_dpath.sv */
module ccmb_dpath #(
  parameter int MAX_CELLS      = 64,
  parameter int MAX_WINDOW_DIM = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ccmb_pkg::cmd_t                 cmd,
  output ccmb_pkg::sts_t                 sts,
  input  logic                           cfg_wen,
  input  logic [ccmb_pkg::CFG_IDX_W-1:0] cfg_windex,
  input  logic [ccmb_pkg::DIM_RAW_W-1:0] cfg_wdata,
  input  logic [ccmb_pkg::ROW_W-1:0]     cell_row,
  input  logic [ccmb_pkg::ROW_W-1:0]     cell_col,
  input  logic [ccmb_pkg::CHG_W-1:0]     cell_charge,
  input  logic                           last_cell,
  output logic [ccmb_pkg::CHG_W-1:0]     window_value,
  output logic [ccmb_pkg::OIDX_W-1:0]    window_index,
  output logic                           last_value
);
  import ccmb_pkg::*;

  localparam int CNW       = $clog2(MAX_CELLS + 1);
  localparam int CA        = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int DW        = $clog2(MAX_WINDOW_DIM + 1);
  localparam int WIN_SLOTS = MAX_WINDOW_DIM * MAX_WINDOW_DIM;
  localparam int WA        = (WIN_SLOTS > 1) ? $clog2(WIN_SLOTS) : 1;
  localparam int CELL_W    = 2 * ROW_W + CHG_W;

  // configuration
  logic [DIM_RAW_W-1:0] rows_raw_r, cols_raw_r;
  logic [DW-1:0]        rows_c, cols_c;
  logic [2*DW-1:0]      slots_n;

  // cell loading
  logic [CELL_W-1:0]    cell_mem_r [MAX_CELLS];
  logic [CNW-1:0]       cnt_r;
  logic                 keep_r, last_r;
  logic [ROW_W-1:0]     row_r, col_r;
  logic [CHG_W-1:0]     chg_r;
  logic [PROD_W-1:0]    prow_r, pcol_r;
  logic [SUM_W-1:0]     rsum_r, csum_r;
  logic [TOT_W-1:0]     tot_r;
  logic [SUM_W:0]       rsum_add, csum_add;
  logic [TOT_W:0]       tot_add;
  logic                 keep_nxt;

  // centroid
  logic [QW-1:0]        qrow, qcol;
  logic                 drow_done, dcol_done;
  logic signed [POS_W-1:0] drow_r, dcol_r;
  logic [QW-1:0]        crow, ccol;

  // placement
  logic [CNW-1:0]       pcnt_r;
  logic [CELL_W-1:0]    cq_r;
  logic                 cq_vld_r;
  logic signed [POS_W-1:0] im, jm;
  logic                 in_win;
  logic [2*DW-1:0]      widx_full;
  logic [WA-1:0]        widx;

  // window and readout
  logic [CHG_W-1:0]     win_mem_r [WIN_SLOTS];
  logic [WIN_SLOTS-1:0] win_vld_r;
  logic [WA-1:0]        opos_r;
  logic [CHG_W-1:0]     wq_r;
  logic                 wq_vld_r;
  logic [OIDX_W-1:0]    oidx_r;
  logic                 olast_r;

  function automatic logic [DW-1:0] clamp_dim(input logic [DIM_RAW_W-1:0] v);
    logic [DIM_RAW_W:0] w;
    w = {1'b0, v};
    if (v == '0) begin
      clamp_dim = DW'(1);
    end else if (w > (DIM_RAW_W + 1)'(MAX_WINDOW_DIM)) begin
      clamp_dim = DW'(MAX_WINDOW_DIM);
    end else begin
      clamp_dim = DW'(v);
    end
  endfunction

  always_comb begin
    rows_c  = clamp_dim(rows_raw_r);
    cols_c  = clamp_dim(cols_raw_r);
    slots_n = (2*DW)'(rows_c) * (2*DW)'(cols_c);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_raw_r <= DIM_RESET;
      cols_raw_r <= DIM_RESET;
    end else if (cfg_wen) begin
      case (cfg_windex)
        REG_WINDOW_ROWS: rows_raw_r <= cfg_wdata;
        REG_WINDOW_COLS: cols_raw_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign keep_nxt = cnt_r < CNW'(MAX_CELLS);

  always_comb begin
    rsum_add = {1'b0, rsum_r} + (SUM_W + 1)'(prow_r);
    csum_add = {1'b0, csum_r} + (SUM_W + 1)'(pcol_r);
    tot_add  = {1'b0, tot_r} + (TOT_W + 1)'(chg_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      rsum_r <= '0;
      csum_r <= '0;
      tot_r  <= '0;
      keep_r <= 1'b0;
      last_r <= 1'b0;
    end else if (cmd.finish) begin
      cnt_r  <= '0;
      rsum_r <= '0;
      csum_r <= '0;
      tot_r  <= '0;
    end else if (cmd.load) begin
      keep_r <= keep_nxt;
      last_r <= last_cell;
      if (keep_nxt) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end else if (cmd.acc && keep_r) begin
      rsum_r <= rsum_add[SUM_W] ? '1 : rsum_add[SUM_W-1:0];
      csum_r <= csum_add[SUM_W] ? '1 : csum_add[SUM_W-1:0];
      tot_r  <= tot_add[TOT_W]  ? '1 : tot_add[TOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      row_r <= cell_row;
      col_r <= cell_col;
      chg_r <= cell_charge;
      if (keep_nxt) begin
        cell_mem_r[cnt_r[CA-1:0]] <= {cell_charge, cell_col, cell_row};
      end
    end
    if (cmd.mul) begin
      prow_r <= PROD_W'(row_r) * PROD_W'(chg_r);
      pcol_r <= PROD_W'(col_r) * PROD_W'(chg_r);
    end
    if (cmd.place) begin
      cq_r <= cell_mem_r[pcnt_r[CA-1:0]];
    end
  end

  ccmb_div u_div_row (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (rsum_r),
    .divisor  (tot_r),
    .quotient (qrow),
    .done     (drow_done)
  );

  ccmb_div u_div_col (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (csum_r),
    .divisor  (tot_r),
    .quotient (qcol),
    .done     (dcol_done)
  );

  assign crow = (tot_r == '0) ? '0 : qrow;
  assign ccol = (tot_r == '0) ? '0 : qcol;

  always_ff @(posedge clk) begin
    if (cmd.centre) begin
      drow_r <= $signed(POS_W'(crow)) - $signed(POS_W'(rows_c >> 1));
      dcol_r <= $signed(POS_W'(ccol)) - $signed(POS_W'(cols_c >> 1));
    end
  end

  always_comb begin
    im        = $signed(POS_W'(cq_r[ROW_W-1:0])) - drow_r;
    jm        = $signed(POS_W'(cq_r[2*ROW_W-1:ROW_W])) - dcol_r;
    in_win    = !im[POS_W-1] && !jm[POS_W-1] &&
                (im < $signed(POS_W'(rows_c))) && (jm < $signed(POS_W'(cols_c)));
    widx_full = (2*DW)'(im[DW-1:0]) * (2*DW)'(cols_c) + (2*DW)'(jm[DW-1:0]);
    widx      = WA'(widx_full);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcnt_r    <= '0;
      cq_vld_r  <= 1'b0;
      win_vld_r <= '0;
      opos_r    <= '0;
    end else begin
      cq_vld_r <= cmd.place;
      if (cmd.centre) begin
        pcnt_r    <= '0;
        win_vld_r <= '0;
        opos_r    <= '0;
      end else begin
        if (cmd.place) begin
          pcnt_r <= pcnt_r + 1'b1;
        end
        if (cq_vld_r && in_win) begin
          win_vld_r[widx] <= 1'b1;
        end
        if (cmd.advance) begin
          opos_r <= opos_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cq_vld_r && in_win) begin
      win_mem_r[widx] <= cq_r[CELL_W-1:2*ROW_W];
    end
    if (cmd.fetch) begin
      wq_r     <= win_mem_r[opos_r];
      wq_vld_r <= win_vld_r[opos_r];
      oidx_r   <= OIDX_W'(opos_r);
      olast_r  <= ((2*DW)'(opos_r) + 1'b1) == slots_n;
    end
  end

  assign window_value = wq_vld_r ? wq_r : '0;
  assign window_index = oidx_r;
  assign last_value   = olast_r;

  always_comb begin
    sts.clus_last  = last_r;
    sts.div_done   = drow_done && dcol_done;
    sts.place_last = (pcnt_r + 1'b1) == cnt_r;
    sts.out_last   = olast_r;
  end

endmodule

/* rtl/core/ccmb_ctrl.sv */
module ccmb_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  output ccmb_pkg::cmd_t cmd,
  input  ccmb_pkg::sts_t sts
);
  import ccmb_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_MUL    = 10'b00_0000_0010,
    S_ACC    = 10'b00_0000_0100,
    S_DSTART = 10'b00_0000_1000,
    S_DIV    = 10'b00_0001_0000,
    S_CTR    = 10'b00_0010_0000,
    S_PLACE  = 10'b00_0100_0000,
    S_DRAIN  = 10'b00_1000_0000,
    S_FETCH  = 10'b01_0000_0000,
    S_OUT    = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = sts.clus_last ? S_DSTART : S_IDLE;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_CTR;
        end
      end
      S_CTR: begin
        cmd.centre = 1'b1;
        state_nxt  = S_PLACE;
      end
      S_PLACE: begin
        cmd.place = 1'b1;
        if (sts.place_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FETCH;
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (sts.out_last) begin
            cmd.finish = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            cmd.advance = 1'b1;
            state_nxt   = S_FETCH;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/core/cluster_charge_matrix_builder.sv */
// Builds a charge window around the centroid of one pixel cluster. Cells arrive one beat
// each and pass through accept, multiply and saturating accumulate; the beat with tlast
// ends the cluster. The block then runs two 11-step restoring dividers in parallel for the
// row and column centroid, centres the window and clears its valid bits, places one stored
// cell per cycle from the cell memory, then passes a drain state, and reads the window out
// row-major in rows*cols beats, each a window memory read and then an output hold, the
// final one with tlast. Cells beyond MAX_CELLS are dropped but their tlast still closes
// the cluster. No input is taken while a cluster is being built or read out.
module cluster_charge_matrix_builder #(
  parameter int MAX_CELLS      = 64,
  parameter int MAX_WINDOW_DIM = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [39:0]                    in_tdata,   // cell_row, cell_col, cell_charge, pad
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [23:0]                    out_tdata,  // window_value, window_index, pad
  output logic                           out_tlast,
  input  logic                           cfg_wen,
  input  logic [ccmb_pkg::CFG_IDX_W-1:0] cfg_windex,
  input  logic [ccmb_pkg::DIM_RAW_W-1:0] cfg_wdata
);
  import ccmb_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  logic [CHG_W-1:0]  window_value;
  logic [OIDX_W-1:0] window_index;

  ccmb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  ccmb_dpath #(
    .MAX_CELLS      (MAX_CELLS),
    .MAX_WINDOW_DIM (MAX_WINDOW_DIM)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_wen      (cfg_wen),
    .cfg_windex   (cfg_windex),
    .cfg_wdata    (cfg_wdata),
    .cell_row     (in_tdata[9:0]),
    .cell_col     (in_tdata[19:10]),
    .cell_charge  (in_tdata[35:20]),
    .last_cell    (in_tlast),
    .window_value (window_value),
    .window_index (window_index),
    .last_value   (out_tlast)
  );

  assign out_tdata = {2'b00, window_index, window_value};

`include "cluster_charge_matrix_builder_assert.svh"

  `CCMB_ASSERT_NOW(a_no_overlap, in_tready, !out_tvalid, "input ready during readout")
  `CCMB_ASSERT_NOW(a_cmd_excl, 1'b1, $onehot0(cmd), "more than one datapath command")
  `CCMB_ASSERT_NEXT(a_busy_after_beat, in_tvalid && in_tready, !in_tready,
                    "input ready right after an accepted cell")
  `CCMB_ASSERT_NEXT(a_idle_after_frame, out_tvalid && out_tready && out_tlast, in_tready,
                    "not ready after final window beat")

endmodule

/* verif/charge_window_checker.sv */
`timescale 1ns / 1ps
module charge_window_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [39:0]                    in_tdata,   // cell_row, cell_col, cell_charge, pad
  input  logic                           in_tlast,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [23:0]                    out_tdata,  // window_value, window_index, pad
  input  logic                           out_tlast,
  input  logic                           cfg_wen,
  input  logic [ccmb_pkg::CFG_IDX_W-1:0] cfg_windex,
  input  logic [ccmb_pkg::DIM_RAW_W-1:0] cfg_wdata,
  output int                             mismatches,
  output int                             beats_pending,
  output int                             beats_checked,
  output int                             clusters_built
);
  import ccmb_pkg::*;

  localparam int CELL_CAP = 64;
  localparam int DIM_CAP  = 8;
  localparam longint unsigned WSUM_MAX = 64'hFFFF_FFFF;
  localparam longint unsigned CHG_MAX  = 64'h3F_FFFF;

  typedef struct packed {
    logic [15:0] value;
    logic [5:0]  index;
    logic        last;
  } win_beat_t;

  win_beat_t       window_due [$];
  logic [9:0]      row_mem [CELL_CAP];
  logic [9:0]      col_mem [CELL_CAP];
  logic [15:0]     chg_mem [CELL_CAP];
  int              held;
  longint unsigned row_wsum, col_wsum, chg_sum;
  logic [3:0]      rows_reg, cols_reg;
  int              fault_count, checked_count, cluster_count, due_count;

  assign mismatches     = fault_count;
  assign beats_pending  = due_count;
  assign beats_checked  = checked_count;
  assign clusters_built = cluster_count;

  function automatic int fit_dim(input logic [3:0] raw);
    if (raw == 4'd0) return 1;
    if (raw > DIM_CAP) return DIM_CAP;
    return int'(raw);
  endfunction

  function automatic longint unsigned sat_add(input longint unsigned acc,
                                              input longint unsigned add,
                                              input longint unsigned lim);
    return (acc + add > lim) ? lim : acc + add;
  endfunction

  task automatic report_mismatch(input string msg);
    if (fault_count < 200) $display("%0t ns mismatch: %s", $time, msg);
    fault_count++;
  endtask

  task automatic load_cell(input logic [9:0] r, input logic [9:0] c, input logic [15:0] q);
    if (held < CELL_CAP) begin
      row_mem[held] = r;
      col_mem[held] = c;
      chg_mem[held] = q;
      held++;
      row_wsum = sat_add(row_wsum, longint'(r) * longint'(q), WSUM_MAX);
      col_wsum = sat_add(col_wsum, longint'(c) * longint'(q), WSUM_MAX);
      chg_sum  = sat_add(chg_sum, longint'(q), CHG_MAX);
    end
  endtask

  task automatic build_window();
    int          nr, nc, crow, ccol, top_row, left_col, im, jm, n;
    logic [15:0] grid [DIM_CAP*DIM_CAP];
    win_beat_t   beat;
    nr   = fit_dim(rows_reg);
    nc   = fit_dim(cols_reg);
    crow = 0;
    ccol = 0;
    if (chg_sum != 0) begin
      crow = int'(row_wsum / chg_sum);
      ccol = int'(col_wsum / chg_sum);
    end
    top_row  = crow - nr / 2;
    left_col = ccol - nc / 2;
    foreach (grid[k]) grid[k] = 16'd0;
    for (int k = 0; k < held; k++) begin
      im = int'(row_mem[k]) - top_row;
      jm = int'(col_mem[k]) - left_col;
      if (im >= 0 && im < nr && jm >= 0 && jm < nc) grid[im * nc + jm] = chg_mem[k];
    end
    n = nr * nc;
    for (int k = 0; k < n; k++) begin
      beat.value = grid[k];
      beat.index = 6'(k);
      beat.last  = (k == n - 1);
      window_due.push_back(beat);
    end
    held     = 0;
    row_wsum = 0;
    col_wsum = 0;
    chg_sum  = 0;
    cluster_count++;
  endtask

  task automatic check_beat();
    win_beat_t want;
    if (window_due.size() == 0) begin
      report_mismatch($sformatf("beat with nothing due: value %0d index %0d last %0b",
                                out_tdata[15:0], out_tdata[21:16], out_tlast));
    end else begin
      want = window_due.pop_front();
      if (out_tdata[15:0] != want.value)
        report_mismatch($sformatf("window_value %0d, due %0d at index %0d",
                                  out_tdata[15:0], want.value, want.index));
      if (out_tdata[21:16] != want.index)
        report_mismatch($sformatf("window_index %0d, due %0d",
                                  out_tdata[21:16], want.index));
      if (out_tlast != want.last)
        report_mismatch($sformatf("last_value %0b, due %0b at index %0d",
                                  out_tlast, want.last, want.index));
      checked_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      window_due.delete();
      held     = 0;
      row_wsum = 0;
      col_wsum = 0;
      chg_sum  = 0;
      rows_reg = DIM_RESET;
      cols_reg = DIM_RESET;
    end else begin
      if (out_tvalid && out_tready) check_beat();
      if (cfg_wen) begin
        case (cfg_windex)
          REG_WINDOW_ROWS: rows_reg = cfg_wdata;
          REG_WINDOW_COLS: cols_reg = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        load_cell(in_tdata[9:0], in_tdata[19:10], in_tdata[35:20]);
        if (in_tlast) build_window();
      end
    end
    due_count = window_due.size();
  end

endmodule

/* verif/tb_cluster_charge_matrix_builder.sv */
`timescale 1ns / 1ps
module tb_cluster_charge_matrix_builder;
  import ccmb_pkg::*;

  localparam int PHASES      = 10;
  localparam int PHASE_CELLS = 22;
  localparam int STALL_LIMIT = 2000;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [39:0]          in_tdata   = '0;
  logic                 in_tlast   = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [23:0]          out_tdata;
  logic                 out_tlast;
  logic                 cfg_wen    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_windex = REG_WINDOW_ROWS;
  logic [DIM_RAW_W-1:0] cfg_wdata  = '0;

  int mismatches, beats_pending, beats_checked, clusters_built;
  int cells_sent;
  int idle_cycles;
  bit in_steady;
  bit out_steady;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  cluster_charge_matrix_builder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wen    (cfg_wen),
    .cfg_windex (cfg_windex),
    .cfg_wdata  (cfg_wdata)
  );

  charge_window_checker u_window_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .cfg_wen        (cfg_wen),
    .cfg_windex     (cfg_windex),
    .cfg_wdata      (cfg_wdata),
    .mismatches     (mismatches),
    .beats_pending  (beats_pending),
    .beats_checked  (beats_checked),
    .clusters_built (clusters_built)
  );

  task automatic send_cell(input logic [9:0] r, input logic [9:0] c,
                           input logic [15:0] q, input bit fin);
    int gap;
    gap = in_steady ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, q, c, r};
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    cells_sent++;
  endtask

  function automatic int jitter_bin(input int centre, input int spread);
    int v;
    v = centre + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return v;
  endfunction

  function automatic int draw_charge();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 0;
    if (pick == 1) return 65535;
    return $urandom_range(0, 65535);
  endfunction

  // mostly tight clusters around a random seed cell, with stray hits
  task automatic send_cluster(input int cells);
    int r0, c0, r, c;
    r0 = $urandom_range(0, 1023);
    c0 = $urandom_range(0, 1023);
    for (int k = 0; k < cells; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        r = $urandom_range(0, 1023);
        c = $urandom_range(0, 1023);
      end else begin
        r = jitter_bin(r0, 4);
        c = jitter_bin(c0, 4);
      end
      send_cell(10'(r), 10'(c), 16'(draw_charge()), k == cells - 1);
    end
  endtask

  // overfills the cell store; the closing cell is dropped
  task automatic send_crowd(input int cells, input bit maxed);
    int r0, c0;
    r0 = $urandom_range(0, 1023);
    c0 = $urandom_range(0, 1023);
    for (int k = 0; k < cells; k++) begin
      if (maxed) send_cell(10'd1023, 10'd1023, 16'hFFFF, k == cells - 1);
      else send_cell(10'(jitter_bin(r0, 3)), 10'(jitter_bin(c0, 3)), 16'(draw_charge()),
                     k == cells - 1);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (beats_pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic set_window(input logic [3:0] r, input logic [3:0] c);
    cfg_wen    <= 1'b1;
    cfg_windex <= REG_WINDOW_ROWS;
    cfg_wdata  <= r;
    @(negedge clk);
    cfg_windex <= REG_WINDOW_COLS;
    cfg_wdata  <= c;
    @(negedge clk);
    cfg_wen    <= 1'b0;
  endtask

  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      stall = out_steady ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: %0d cycles without a beat, %0d beats still due",
               idle_cycles, beats_pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int phase_start;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset window 7x7: zero charge, extremes, overwrite, off-window cells
    send_cell(10'd0, 10'd0, 16'd0, 1'b1);
    send_cell(10'd1023, 10'd1023, 16'hFFFF, 1'b1);
    send_cell(10'd5, 10'd5, 16'd100, 1'b0);
    send_cell(10'd5, 10'd5, 16'd200, 1'b0);
    send_cell(10'd6, 10'd7, 16'hFFFF, 1'b1);
    send_cell(10'd0, 10'd0, 16'd1, 1'b0);
    send_cell(10'd1023, 10'd1023, 16'd1, 1'b1);
    send_cell(10'h2AA, 10'h155, 16'hAAAA, 1'b0);
    send_cell(10'h155, 10'h2AA, 16'h5555, 1'b1);
    send_cell(10'd3, 10'd4, 16'd0, 1'b0);
    send_cell(10'd900, 10'd2, 16'd0, 1'b1);
    send_cell(10'd100, 10'd100, 16'hFFFF, 1'b0);
    send_cell(10'd103, 10'd96, 16'd1, 1'b0);
    send_cell(10'd97, 10'd103, 16'd1, 1'b1);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      in_steady  = ($urandom_range(0, 3) == 0);
      out_steady = ($urandom_range(0, 3) == 0);
      case (p)
        0: set_window(4'd1, 4'd1);
        1: set_window(4'd8, 4'd8);
        2: set_window(4'd0, 4'd15);
        3: set_window(4'd15, 4'd0);
        4: set_window(4'd1, 4'd8);
        5: set_window(4'd8, 4'd1);
        default: set_window(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      endcase
      phase_start = cells_sent;
      while (cells_sent - phase_start < PHASE_CELLS) begin
        if ($urandom_range(0, 7) == 0) send_cluster($urandom_range(9, 20));
        else send_cluster($urandom_range(1, 8));
      end
      if (p == 1) send_crowd(65, 1'b1);
      if (p == 6) send_crowd(70, 1'b0);
      drain();
    end

    $display("run covered %0d cells in %0d clusters, %0d window beats checked",
             cells_sent, clusters_built, beats_checked);
    $display("windows 1x1 to 8x8 incl. clamped sizes, overfull store, zero charge: %0d errors",
             mismatches);
    if (mismatches == 0 && beats_pending == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
